>>> sv/lmm_pkg.sv
package lmm_pkg;

    // Field widths fixed by the stream format
    localparam int UNIT_W     = 32;
    localparam int FMT_W      = 3;
    localparam int PIX_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_SHIFT  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_DEPTH  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_GRAY8  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_GRAY16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_YUV422 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 3'd5;
    // Codes with no mirror
    localparam logic [FMT_W-1:0] FMT_RSVD6  = 3'd6;
    localparam logic [FMT_W-1:0] FMT_RSVD7  = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [FMT_W-1:0] PIXEL_FORMAT_RST = FMT_SHIFT;
    localparam logic [PIX_W-1:0] LINE_PIXELS_RST  = 14'd640;

    // Item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_FORMAT = 2'd2
    } status_t;

    // Byte mask of one unit; zero marks a format with no mirror
    function automatic logic [UNIT_W-1:0] unit_mask(input logic [FMT_W-1:0] fmt);
        logic [UNIT_W-1:0] m;
        unique case (fmt) inside
            FMT_SHIFT, FMT_DEPTH, FMT_GRAY16: m = 32'h0000_FFFF;
            FMT_GRAY8:                        m = 32'h0000_00FF;
            FMT_YUV422:                       m = 32'hFFFF_FFFF;
            FMT_RGB24:                        m = 32'h00FF_FFFF;
            default:                          m = '0;
        endcase
        return m;
    endfunction

    // Swap the two luma bytes of a U,Y1,V,Y2 macropixel
    function automatic logic [UNIT_W-1:0] swap_luma(input logic [UNIT_W-1:0] v);
        return {v[15:8], v[23:16], v[31:24], v[7:0]};
    endfunction

endpackage

>>> sv/lmm_if.sv
interface lmm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] unit_data;

    modport source (output valid, output operation, output unit_data, input ready);
    modport sink   (input valid, input operation, input unit_data, output ready);
endinterface

interface lmm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mirrored_unit;
    logic        last_in_line;
    logic [1:0]  status;

    modport source (output valid, output mirrored_unit, output last_in_line,
                    output status, input ready);
    modport sink   (input valid, input mirrored_unit, input last_in_line,
                    input status, output ready);
endinterface

>>> sv/line_mirror_multi_format.sv
// Horizontal line mirror for a raster pixel stream.
// in_ch carries one beat per pixel unit (1, 2 or 3 byte pixel, or a 4 byte
// YUV422 macropixel), or a drain beat that reads out the pending line.
// out_ch carries mirrored units in reverse order within each line, with
// last_in_line on the final unit, or an error beat (status nonzero, zero
// data) for every item while the format or line length is invalid.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
// the user must write it only while the block is idle; the block does not enforce this.
// Two banks of MAX_UNITS units sit in one synchronous RAM: the line being
// written goes to one bank while the previous line is read from the other.
// Each accepted beat does at most one RAM read and one RAM write.
// Throughput: one beat per cycle while out_ch does not stall. The edge that
// accepts an input beat loads the RAM read register and the read stage; the
// output register loads from them when the read stage advances.
// When out_ch stalls, in_ch keeps accepting until both the read stage and
// the output register hold results, then ready drops.
// Reset clears positions, bank select and pending flag; RAM contents are
// not cleared and there is no clearing pass.
module line_mirror_multi_format
    import lmm_pkg::*;
#(
    parameter int MAX_UNITS = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lmm_in_if.sink                in_ch,
    lmm_out_if.source             out_ch
);

    localparam int POS_W = $clog2(MAX_UNITS);
    localparam int DEPTH = 2 * MAX_UNITS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PIX_W-1:0] MAX_UNITS_W = PIX_W'(MAX_UNITS);
    localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(MAX_UNITS);

    // Configuration
    logic [FMT_W-1:0] pixel_format_reg;
    logic [PIX_W-1:0] line_pixels_reg;

    // Line state
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    logic [POS_W-1:0] read_pos_reg, read_pos_next;
    logic             write_bank_reg, write_bank_next;
    logic             pending_reg, pending_next;

    // Read stage and output register
    logic              s1_valid_reg;
    logic [UNIT_W-1:0] s1_mask_reg;
    logic              s1_last_reg;
    status_t           s1_status_reg;
    logic [UNIT_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg;
    logic              out_last_reg;
    status_t           out_status_reg;

    logic [UNIT_W-1:0] line_store [DEPTH];

    logic              accept;
    logic              advance;
    logic [UNIT_W-1:0] mask;
    logic [PIX_W-1:0]  units;
    logic [PIX_W-1:0]  units_m1;
    status_t           item_status;
    logic              item_ok;
    logic              rd_en;
    logic              wr_en;
    logic [PIX_W-1:0]  rd_pos_full;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [UNIT_W-1:0] wr_data;
    logic              rd_last;
    logic              wr_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= PIXEL_FORMAT_RST;
            line_pixels_reg  <= LINE_PIXELS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[FMT_W-1:0];
                CFG_LINE_PIXELS:  line_pixels_reg  <= cfg_data[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // Decode format and line length
    always_comb
    begin
        mask     = unit_mask(pixel_format_reg);
        units    = (pixel_format_reg == FMT_YUV422) ? (line_pixels_reg >> 1)
                                                    : line_pixels_reg;
        units_m1 = units - PIX_W'(1);
        if (mask == '0)
            item_status = STATUS_BAD_FORMAT;
        else if (units == '0 || units > MAX_UNITS_W)
            item_status = STATUS_BAD_LENGTH;
        else
            item_status = STATUS_OK;
        item_ok = (item_status == STATUS_OK);
    end

    // Handshake: room while the read stage is empty or can move on
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Read side: reverse unit order from the bank not being written
    always_comb
    begin
        rd_en       = accept && item_ok && pending_reg;
        rd_pos_full = (PIX_W'(read_pos_reg) < units) ? (units_m1 - PIX_W'(read_pos_reg))
                                                     : '0;
        rd_addr     = (write_bank_reg ? '0 : BANK_OFS) + ADDR_W'(rd_pos_full[POS_W-1:0]);
        rd_last     = PIX_W'(read_pos_reg) >= units_m1;
    end

    // Write side: masked unit (luma bytes swapped for YUV422) into the current bank
    always_comb
    begin
        wr_en   = accept && item_ok && (in_ch.operation == OP_WRITE);
        wr_addr = (write_bank_reg ? BANK_OFS : '0) + ADDR_W'(write_pos_reg);
        wr_data = in_ch.unit_data & mask;
        if (pixel_format_reg == FMT_YUV422)
            wr_data = swap_luma(wr_data);
        wr_last = PIX_W'(write_pos_reg) >= units_m1;
    end

    // Next line state: read update first, a finished write line overrides it
    always_comb
    begin
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        write_bank_next = write_bank_reg;
        pending_next    = pending_reg;
        if (rd_en)
        begin
            if (rd_last)
            begin
                pending_next  = 1'b0;
                read_pos_next = '0;
            end
            else
                read_pos_next = read_pos_reg + POS_W'(1);
        end
        if (wr_en)
        begin
            if (wr_last)
            begin
                write_pos_next  = '0;
                write_bank_next = !write_bank_reg;
                pending_next    = 1'b1;
                read_pos_next   = '0;
            end
            else
                write_pos_next = write_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            write_bank_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            write_bank_reg <= write_bank_next;
            pending_reg    <= pending_next;
        end
    end

    // Line store: read and write always hit opposite banks in the same cycle, and a
    // read in the cycle after a bank flip sees the write committed on that edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_store[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= line_store[rd_addr];
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= !item_ok || pending_reg;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mask_reg   <= mask;
            s1_last_reg   <= item_ok && rd_last;
            s1_status_reg <= item_status;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload: error beats carry zero data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_unit_reg   <= (s1_status_reg == STATUS_OK) ? (rd_data_reg & s1_mask_reg) : '0;
            out_last_reg   <= s1_last_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.mirrored_unit = out_unit_reg;
    assign out_ch.last_in_line  = out_last_reg;
    assign out_ch.status        = out_status_reg;

    // An error beat never carries data or an end-of-line mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_OK |->
            out_unit_reg == '0 && !out_last_reg)
        else $error("error beat with data");

    // A valid item against a pending line always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_ok && pending_reg |=> s1_valid_reg)
        else $error("pending read lost");

    // A valid item with no pending line yields no result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_ok && !pending_reg |=> !s1_valid_reg)
        else $error("result invented");

    // A full read stage that cannot move on blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !in_ch.ready)
        else $error("input accepted over a held result");

endmodule
